### rtl/pgen_pkg.sv
package pgen_pkg;

    localparam int MAX_ELEMENTS_DEF = 8;
    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int NUM_OUT          = 8;
    localparam int OUT_W            = 32;
    localparam int LEN_W            = 4;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_NEXT   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_I,
        ST_FIND_J,
        ST_SWAP,
        ST_REVERSE,
        ST_GATHER,
        ST_DRAIN,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic clear_list;
        logic append;
        logic begin_req;
        logic load_exh;
        logic dec_a;
        logic take_pivot;
        logic dec_b;
        logic swap_pivot;
        logic swap_rev;
        logic issue_read;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic finished;
        logic started;
        logic short_list;
        logic empty;
        logic pivot_hit;
        logic a_at_one;
        logic j_stop;
        logic rev_more;
        logic k_last;
    } status_t;

endpackage

### rtl/pgen_req_if.sv
interface pgen_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic signed [31:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

### rtl/pgen_rsp_if.sv
interface pgen_rsp_if
    import pgen_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] elem_0;
    logic signed [OUT_W-1:0] elem_1;
    logic signed [OUT_W-1:0] elem_2;
    logic signed [OUT_W-1:0] elem_3;
    logic signed [OUT_W-1:0] elem_4;
    logic signed [OUT_W-1:0] elem_5;
    logic signed [OUT_W-1:0] elem_6;
    logic signed [OUT_W-1:0] elem_7;
    logic [LEN_W-1:0]        perm_length;
    logic                    final_one;
    logic                    exhausted;

    modport source (
        output valid, output elem_0, output elem_1, output elem_2, output elem_3,
        output elem_4, output elem_5, output elem_6, output elem_7,
        output perm_length, output final_one, output exhausted, input ready
    );
    modport sink (
        input valid, input elem_0, input elem_1, input elem_2, input elem_3,
        input elem_4, input elem_5, input elem_6, input elem_7,
        input perm_length, input final_one, input exhausted, output ready
    );
endinterface

### rtl/pgen_ctrl.sv
module pgen_ctrl
    import pgen_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  logic [1:0] req_op,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    op_t    op;

    assign op = op_t'(req_op);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && op == OP_NEXT)
                begin
                    if (status.finished)
                        state_next = ST_OUTPUT;
                    else if (status.started && !status.short_list)
                        state_next = ST_FIND_I;
                    else if (status.empty)
                        state_next = ST_DRAIN;
                    else
                        state_next = ST_GATHER;
                end
            end
            ST_FIND_I:
            begin
                if (status.pivot_hit)
                    state_next = ST_FIND_J;
                else if (status.a_at_one)
                    state_next = ST_GATHER;
            end
            ST_FIND_J:
            begin
                if (status.j_stop)
                    state_next = ST_SWAP;
            end
            ST_SWAP:    state_next = ST_REVERSE;
            ST_REVERSE:
            begin
                if (!status.rev_more)
                    state_next = ST_GATHER;
            end
            ST_GATHER:
            begin
                if (status.k_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:   state_next = ST_OUTPUT;
            ST_OUTPUT:
            begin
                if (rsp_ready)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    case (op)
                        OP_CLEAR:  cmd.clear_list = 1'b1;
                        OP_APPEND: cmd.append     = 1'b1;
                        OP_NEXT:
                        begin
                            if (status.finished)
                                cmd.load_exh = 1'b1;
                            else
                                cmd.begin_req = 1'b1;
                        end
                        default:   cmd = '0;
                    endcase
                end
            end
            ST_FIND_I:
            begin
                if (status.pivot_hit)
                    cmd.take_pivot = 1'b1;
                else
                    cmd.dec_a = 1'b1;
            end
            ST_FIND_J:
            begin
                if (!status.j_stop)
                    cmd.dec_b = 1'b1;
            end
            ST_SWAP:    cmd.swap_pivot = 1'b1;
            ST_REVERSE:
            begin
                if (status.rev_more)
                    cmd.swap_rev = 1'b1;
            end
            ST_GATHER:  cmd.issue_read = 1'b1;
            ST_DRAIN:   cmd.finish = 1'b1;
            ST_OUTPUT:  rsp_valid = 1'b1;
            default:    cmd = '0;
        endcase
    end

endmodule

### rtl/pgen_datapath.sv
module pgen_datapath
    import pgen_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cmd_t                            cmd,
    input  logic signed [31:0]              value,
    output status_t                         status,
    output logic [NUM_OUT-1:0][OUT_W-1:0]   elems,
    output logic [LEN_W-1:0]                perm_length,
    output logic                            final_one,
    output logic                            exhausted
);

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int EXT_W = (VALUE_WIDTH > OUT_W) ? VALUE_WIDTH : OUT_W;

    logic [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];

    logic [IDX_W-1:0] order_reg [MAX_ELEMENTS];
    logic [IDX_W-1:0] order_next [MAX_ELEMENTS];
    logic [CNT_W-1:0] count_reg;
    logic             started_reg;
    logic             finished_reg;
    logic [IDX_W-1:0] a_reg;
    logic [IDX_W-1:0] b_reg;
    logic [IDX_W-1:0] piv_reg;
    logic [IDX_W-1:0] k_reg;
    logic             wr_en_reg;
    logic [IDX_W-1:0] wr_pos_reg;
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [OUT_W-1:0] elem_reg [NUM_OUT];
    logic [LEN_W-1:0] len_reg;
    logic             final_reg;
    logic             exh_reg;

    logic             restart;
    logic             full;
    logic [IDX_W-1:0] n_m1;
    logic [IDX_W-1:0] a_dec;
    logic             last_order;
    logic signed [EXT_W-1:0] ext_value;

    assign restart = cmd.clear_list | cmd.append;
    assign full    = (count_reg == CNT_W'(MAX_ELEMENTS));
    assign n_m1    = IDX_W'(count_reg - 1'b1);
    assign a_dec   = a_reg - 1'b1;
    assign ext_value = EXT_W'(signed'(rd_data_reg));

    assign status.finished   = finished_reg;
    assign status.started    = started_reg;
    assign status.short_list = (count_reg < CNT_W'(2));
    assign status.empty      = (count_reg == '0);
    assign status.pivot_hit  = (order_reg[a_dec] < order_reg[a_reg]);
    assign status.a_at_one   = (a_reg == IDX_W'(1));
    assign status.j_stop     = (order_reg[b_reg] > order_reg[piv_reg]);
    assign status.rev_more   = (a_reg < b_reg);
    assign status.k_last     = (k_reg == n_m1);

    // descending order over the live positions marks the final permutation
    always_comb
    begin
        last_order = 1'b1;
        for (int p = 0; p < MAX_ELEMENTS - 1; p++)
        begin
            if ((CNT_W'(p + 1) < count_reg) && (order_reg[p] < order_reg[p + 1]))
                last_order = 1'b0;
        end
    end

    always_comb
    begin
        for (int p = 0; p < MAX_ELEMENTS; p++)
            order_next[p] = order_reg[p];
        if (restart)
        begin
            for (int p = 0; p < MAX_ELEMENTS; p++)
                order_next[p] = IDX_W'(p);
        end
        else if (cmd.swap_pivot)
        begin
            order_next[piv_reg] = order_reg[b_reg];
            order_next[b_reg]   = order_reg[piv_reg];
        end
        else if (cmd.swap_rev)
        begin
            order_next[a_reg] = order_reg[b_reg];
            order_next[b_reg] = order_reg[a_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < MAX_ELEMENTS; p++)
                order_reg[p] <= IDX_W'(p);
            count_reg    <= '0;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            a_reg        <= '0;
            b_reg        <= '0;
            piv_reg      <= '0;
            k_reg        <= '0;
            wr_en_reg    <= 1'b0;
            wr_pos_reg   <= '0;
        end
        else
        begin
            for (int p = 0; p < MAX_ELEMENTS; p++)
                order_reg[p] <= order_next[p];
            wr_en_reg <= cmd.issue_read;

            if (cmd.clear_list)
                count_reg <= '0;
            else if (cmd.append && !full)
                count_reg <= count_reg + 1'b1;

            if (restart)
            begin
                started_reg  <= 1'b0;
                finished_reg <= 1'b0;
            end
            else if (cmd.begin_req)
            begin
                started_reg <= 1'b1;
            end
            else if (cmd.finish && last_order)
            begin
                finished_reg <= 1'b1;
            end

            if (cmd.begin_req)
            begin
                a_reg <= n_m1;
                k_reg <= '0;
            end
            else if (cmd.dec_a)
            begin
                a_reg <= a_dec;
            end
            else if (cmd.take_pivot)
            begin
                piv_reg <= a_dec;
                b_reg   <= n_m1;
            end
            else if (cmd.dec_b)
            begin
                b_reg <= b_reg - 1'b1;
            end
            else if (cmd.swap_pivot)
            begin
                a_reg <= piv_reg + 1'b1;
                b_reg <= n_m1;
            end
            else if (cmd.swap_rev)
            begin
                a_reg <= a_reg + 1'b1;
                b_reg <= b_reg - 1'b1;
            end
            else if (cmd.issue_read)
            begin
                k_reg      <= k_reg + 1'b1;
                wr_pos_reg <= k_reg;
            end
        end
    end

    // value store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
            mem[count_reg[IDX_W-1:0]] <= VALUE_WIDTH'($unsigned(value));
        rd_data_reg <= mem[order_reg[k_reg]];
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NUM_OUT; p++)
        begin
            if (cmd.begin_req || cmd.load_exh)
                elem_reg[p] <= '0;
            else if (wr_en_reg && (p < MAX_ELEMENTS) && (wr_pos_reg == IDX_W'(p)))
                elem_reg[p] <= ext_value[OUT_W-1:0];
        end
        if (cmd.begin_req)
        begin
            len_reg   <= LEN_W'(count_reg);
            final_reg <= 1'b0;
            exh_reg   <= 1'b0;
        end
        else if (cmd.load_exh)
        begin
            len_reg   <= '0;
            final_reg <= 1'b0;
            exh_reg   <= 1'b1;
        end
        else if (cmd.finish)
        begin
            final_reg <= last_order;
        end
    end

    always_comb
    begin
        for (int p = 0; p < NUM_OUT; p++)
            elems[p] = elem_reg[p];
    end

    assign perm_length = len_reg;
    assign final_one   = final_reg;
    assign exhausted   = exh_reg;

endmodule

### rtl/permutation_generator_core.sv
// permutation generator
// requests come in on req: op clear empties the list, op append adds value to
// the list (dropped once the list is full), op next asks for the next ordering.
// clear and append give no response and restart the sequence.
// each next request gives one response on rsp with the ordered elements, the
// list length and final_one on the last ordering; once that has gone out,
// further next requests answer with exhausted set and all elements zero.
// orderings follow the lexicographic order of element positions, so all n!
// orderings appear even for repeated values; an empty list gives one empty one.
// for a next request the index order is scanned and reversed one position per
// cycle, then the values are gathered through the single read port of the
// value store, one element per cycle.
// one request is handled at a time: req.ready is low from acceptance of a
// next request until its response is taken, so a stalled receiver holds the
// response and the block. reset empties the list and restarts the sequence.
module permutation_generator_core
    import pgen_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pgen_req_if.sink    req,
    pgen_rsp_if.source  rsp
);

    cmd_t    cmd;
    status_t status;
    logic [NUM_OUT-1:0][OUT_W-1:0] elems;

    pgen_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pgen_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value       (req.value),
        .status      (status),
        .elems       (elems),
        .perm_length (rsp.perm_length),
        .final_one   (rsp.final_one),
        .exhausted   (rsp.exhausted)
    );

    assign rsp.elem_0 = elems[0];
    assign rsp.elem_1 = elems[1];
    assign rsp.elem_2 = elems[2];
    assign rsp.elem_3 = elems[3];
    assign rsp.elem_4 = elems[4];
    assign rsp.elem_5 = elems[5];
    assign rsp.elem_6 = elems[6];
    assign rsp.elem_7 = elems[7];

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request taken while a response is pending");

    a_exhausted_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.exhausted) |-> (rsp.perm_length == '0 && !rsp.final_one))
        else $error("exhausted response carries a permutation");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == OP_CLEAR) |=>
            (status.empty && !status.started && !status.finished))
        else $error("clear did not empty the list");

    a_final_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.final_one) |-> status.finished)
        else $error("final permutation sent without marking the end");

endmodule

### tb/permutation_generator_core_tb.sv
module permutation_generator_core_tb;
    import pgen_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 500;
    localparam int TAIL_CYCLES = 60;
    localparam int PRINT_CAP   = 50;
    localparam int PERMS_UPTO4 [5] = '{1, 1, 2, 6, 24};

    typedef struct packed {
        logic [7:0][31:0] elem;
        logic [3:0]       len;
        logic             fin;
        logic             exh;
    } perm_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
        bit          given;
        perm_t       want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    pgen_req_if req_bus ();
    pgen_rsp_if rsp_bus ();

    permutation_generator_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // local copy of the list and the enumeration position
    logic [31:0] list_vals [8];
    int          list_count;
    logic [2:0]  pos_order [8];
    bit          begun;
    bit          done;

    perm_t       perm_q [$];
    stim_row_t   plan [$];
    int          errors;
    int          items;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_go;
    bit          hold_done;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP)
            $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic void restart_order();
        for (int i = 0; i < 8; i++)
            pos_order[i] = i[2:0];
        begun = 1'b0;
        done  = 1'b0;
    endfunction

    function automatic bit next_ordering(input op_t op, input logic [31:0] value,
                                         output perm_t res);
        int         n;
        int         p;
        int         q;
        int         lo;
        int         hi;
        logic [2:0] t;
        bit         last;
        res = '0;
        case (op)
            OP_CLEAR:
            begin
                list_count = 0;
                restart_order();
                return 1'b0;
            end
            OP_APPEND:
            begin
                if (list_count < 8)
                begin
                    list_vals[list_count] = value;
                    list_count++;
                end
                restart_order();
                return 1'b0;
            end
            OP_NEXT:
            begin
                if (done)
                begin
                    res.exh = 1'b1;
                    return 1'b1;
                end
                n = list_count;
                if (begun && n >= 2)
                begin
                    p = -1;
                    for (int i = n - 1; i > 0; i--)
                        if (p < 0 && pos_order[i-1] < pos_order[i])
                            p = i - 1;
                    if (p >= 0)
                    begin
                        q = n - 1;
                        while (pos_order[q] <= pos_order[p])
                            q--;
                        t = pos_order[p];
                        pos_order[p] = pos_order[q];
                        pos_order[q] = t;
                        lo = p + 1;
                        hi = n - 1;
                        while (lo < hi)
                        begin
                            t = pos_order[lo];
                            pos_order[lo] = pos_order[hi];
                            pos_order[hi] = t;
                            lo++;
                            hi--;
                        end
                    end
                end
                begun = 1'b1;
                last = 1'b1;
                for (int i = 0; i + 1 < n; i++)
                    if (pos_order[i] < pos_order[i+1])
                        last = 1'b0;
                for (int k = 0; k < n; k++)
                    res.elem[k] = list_vals[pos_order[k]];
                res.len = n[3:0];
                res.fin = last;
                done = last;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic perm_t mk_perm(input int len, input bit fin, input bit exh,
                                      input logic [31:0] e0, input logic [31:0] e1);
        perm_t p;
        p = '0;
        p.len = len[3:0];
        p.fin = fin;
        p.exh = exh;
        p.elem[0] = e0;
        p.elem[1] = e1;
        return p;
    endfunction

    function automatic stim_row_t row(input op_t op, input logic [31:0] value,
                                      input bit given, input perm_t want);
        stim_row_t r;
        r.op    = op;
        r.value = value;
        r.given = given;
        r.want  = want;
        return r;
    endfunction

    function automatic void add_row(input stim_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic logic [31:0] pick_value(input logic [31:0] prev);
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return prev;
            5:       return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue_request(input op_t op, input logic [31:0] value,
                                 input bit given, input perm_t want);
        perm_t calc;
        bit    has;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.op    <= op;
        req_bus.value <= value;
        do
            @(posedge clk);
        while (!req_bus.ready);
        has = next_ordering(op, value, calc);
        if (has)
            perm_q.insert(perm_q.size(), given ? want : calc);
        if (op != OP_NOP)
            items++;
        @(negedge clk);
    endtask

    // response side
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                repeat (HOLD_CYCLES)
                begin
                    rsp_bus.ready <= 1'b0;
                    @(negedge clk);
                end
                hold_done = 1'b1;
            end
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        perm_t            want;
        logic [7:0][31:0] got_elems;
        if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (perm_q.size() == 0)
                report_mismatch("response with no request outstanding");
            else
            begin
                want = perm_q.pop_front();
                got_elems = {rsp_bus.elem_7, rsp_bus.elem_6, rsp_bus.elem_5, rsp_bus.elem_4,
                             rsp_bus.elem_3, rsp_bus.elem_2, rsp_bus.elem_1, rsp_bus.elem_0};
                for (int k = 0; k < 8; k++)
                    if (got_elems[k] !== want.elem[k])
                        report_mismatch($sformatf("elem_%0d got %h want %h",
                                                  k, got_elems[k], want.elem[k]));
                if (rsp_bus.perm_length !== want.len)
                    report_mismatch($sformatf("perm_length got %0d want %0d",
                                              rsp_bus.perm_length, want.len));
                if (rsp_bus.final_one !== want.fin)
                    report_mismatch($sformatf("final_one got %b want %b",
                                              rsp_bus.final_one, want.fin));
                if (rsp_bus.exhausted !== want.exh)
                    report_mismatch($sformatf("exhausted got %b want %b",
                                              rsp_bus.exhausted, want.exh));
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("permutation_generator_core_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] v;
        int          k;
        int          n;
        int          nexts;
        int          roll;
        req_bus.valid  = 1'b0;
        req_bus.op     = OP_NOP;
        req_bus.value  = '0;
        rst_n          = 1'b0;
        errors         = 0;
        items          = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go        = 1'b0;
        hold_done      = 1'b0;
        list_count     = 0;
        v              = '0;
        for (int i = 0; i < 8; i++)
            list_vals[i] = '0;
        restart_order();

        add_row(row(OP_NEXT,   32'h0,         1, mk_perm(0, 1, 0, 0, 0)));
        add_row(row(OP_NEXT,   32'hffff_ffff, 1, mk_perm(0, 0, 1, 0, 0)));
        add_row(row(OP_NOP,    32'h1234_5678, 0, '0));
        add_row(row(OP_APPEND, 32'h8000_0000, 0, '0));
        add_row(row(OP_NEXT,   32'h0,         1,
                    mk_perm(1, 1, 0, 32'h8000_0000, 0)));
        add_row(row(OP_NEXT,   32'h0,         1, mk_perm(0, 0, 1, 0, 0)));
        add_row(row(OP_APPEND, 32'h7fff_ffff, 0, '0));
        add_row(row(OP_NEXT,   32'h0,         1,
                    mk_perm(2, 0, 0, 32'h8000_0000, 32'h7fff_ffff)));
        add_row(row(OP_NEXT,   32'h0,         1,
                    mk_perm(2, 1, 0, 32'h7fff_ffff, 32'h8000_0000)));
        add_row(row(OP_NEXT,   32'h0,         1, mk_perm(0, 0, 1, 0, 0)));
        add_row(row(OP_APPEND, 32'hffff_ffff, 0, '0));
        add_row(row(OP_NEXT,   32'h0,         0, '0));
        add_row(row(OP_NOP,    32'h0,         0, '0));
        add_row(row(OP_NEXT,   32'h0,         0, '0));
        add_row(row(OP_CLEAR,  32'hffff_ffff, 0, '0));
        add_row(row(OP_NEXT,   32'h0,         1, mk_perm(0, 1, 0, 0, 0)));
        add_row(row(OP_APPEND, 32'h5,         0, '0));
        add_row(row(OP_APPEND, 32'h5,         0, '0));
        add_row(row(OP_NEXT,   32'h0,         1, mk_perm(2, 0, 0, 32'h5, 32'h5)));
        add_row(row(OP_NEXT,   32'h0,         1, mk_perm(2, 1, 0, 32'h5, 32'h5)));
        add_row(row(OP_NEXT,   32'h0,         1, mk_perm(0, 0, 1, 0, 0)));
        add_row(row(OP_CLEAR,  32'h0,         0, '0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
            issue_request(plan[i].op, plan[i].value, plan[i].given, plan[i].want);

        // long receiver hold-off while requests keep coming
        hold_go = 1'b1;

        while (items < ITEM_TARGET)
        begin
            case ((items * 4) / ITEM_TARGET)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 57;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 57;
                end
                default:
                begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase
            if ($urandom_range(99) < 80)
            begin
                if ($urandom_range(99) < 85)
                    issue_request(OP_CLEAR, $urandom, 0, '0);
                roll = $urandom_range(99);
                if (roll < 70)
                    k = $urandom_range(4);
                else if (roll < 92)
                    k = $urandom_range(8, 5);
                else
                    k = $urandom_range(10, 9);
                repeat (k)
                begin
                    v = pick_value(v);
                    issue_request(OP_APPEND, v, 0, '0);
                end
                n = list_count;
                nexts = (n <= 4) ? PERMS_UPTO4[n] + $urandom_range(2) : $urandom_range(12, 1);
                repeat (nexts)
                begin
                    if ($urandom_range(99) < 4)
                        issue_request(op_t'($urandom_range(3)), pick_value(v), 0, '0);
                    issue_request(OP_NEXT, $urandom, 0, '0);
                end
            end
            else
                issue_request(op_t'($urandom_range(3)), pick_value($urandom), 0, '0);
        end
        req_bus.valid <= 1'b0;

        while (perm_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("permutation_generator_core_tb: clean");
        else
            $display("permutation_generator_core_tb: errors");
        $finish;
    end

endmodule
